/* rtl/rbm_pkg.sv */
`default_nettype none
package rbm_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int BLOCK_BITS = 64;
  localparam int ROW_BLOCKS = (MAX_NODES + BLOCK_BITS - 1) / BLOCK_BITS;

  // fixed field widths of the item
  localparam int OP_W = 2;
  localparam int ID_W = 10;

  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int CMP_W   = (CNT_W > ID_W) ? CNT_W : ID_W;
  localparam int ROW_W   = $clog2(MAX_NODES);
  localparam int OFF_W   = $clog2(BLOCK_BITS);
  localparam int BLK_W   = (ROW_BLOCKS > 1) ? $clog2(ROW_BLOCKS) : 1;
  localparam int ADDR_W  = ROW_W + BLK_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  localparam logic [OP_W-1:0] OP_ADD_NODE = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_MERGE,
    ST_QUERY,
    ST_QTAKE,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_MERGE,
    ACT_QUERY
  } act_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic blk_clr;
    logic clear_wr;
    logic merge_rd;
    logic query_rd;
    logic query_take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic blk_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

/* rtl/rbm_in_if.sv */
`default_nettype none
interface rbm_in_if;
  logic                     valid;
  logic                     ready;
  logic [rbm_pkg::OP_W-1:0] operation;
  logic [rbm_pkg::ID_W-1:0] source_node;
  logic [rbm_pkg::ID_W-1:0] target_node;

  modport source (output valid, output operation, output source_node, output target_node,
                  input ready);
  modport sink (input valid, input operation, input source_node, input target_node,
                output ready);
endinterface
`default_nettype wire

/* rtl/rbm_out_if.sv */
`default_nettype none
interface rbm_out_if;
  logic                     valid;
  logic                     ready;
  logic [rbm_pkg::ID_W-1:0] new_node_id;
  logic                     reaches;
  logic                     error;

  modport source (output valid, output new_node_id, output reaches, output error,
                  input ready);
  modport sink (input valid, input new_node_id, input reaches, input error,
                output ready);
endinterface
`default_nettype wire

/* rtl/reachability_bit_matrix.sv */
// flow: an accepted item is decoded; then add node wipes the new row, add edge merges rows
//   (one 64-bit block a cycle), and a query reads a block, before the result is loaded
// items: one in flight; the next item is taken once the previous result is
//   in the output register
// reset: synchronous active-low; a pass then wipes row 0 while in_ch.ready is low
`default_nettype none
module reachability_bit_matrix (
  input wire logic clk,
  input wire logic rst_n,
  rbm_in_if.sink   in_ch,
  rbm_out_if.source out_ch
);

  rbm_pkg::cmd_t  cmd;
  rbm_pkg::stat_t stat;

  rbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rbm_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_operation    (in_ch.operation),
    .in_source_node  (in_ch.source_node),
    .in_target_node  (in_ch.target_node),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_new_node_id (out_ch.new_node_id),
    .out_reaches     (out_ch.reaches),
    .out_error       (out_ch.error)
  );

endmodule
`default_nettype wire

/* rtl/rbm_ctrl.sv */
`default_nettype none
module rbm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rbm_pkg::stat_t stat,
  output rbm_pkg::cmd_t       cmd
);

  rbm_pkg::state_t state_r;
  rbm_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbm_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      // wipe row 0 after reset, the reserved node
      rbm_pkg::ST_INIT: begin
        cmd.clear_wr = 1'b1;
        if (stat.blk_last) begin
          state_nxt = rbm_pkg::ST_IDLE;
        end
      end
      rbm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = rbm_pkg::ST_DECODE;
        end
      end
      rbm_pkg::ST_DECODE: begin
        cmd.decide  = 1'b1;
        cmd.blk_clr = 1'b1;
        case (stat.act)
          rbm_pkg::ACT_CLEAR: state_nxt = rbm_pkg::ST_CLEAR;
          rbm_pkg::ACT_MERGE: state_nxt = rbm_pkg::ST_MERGE;
          rbm_pkg::ACT_QUERY: state_nxt = rbm_pkg::ST_QUERY;
          default:            state_nxt = rbm_pkg::ST_RESULT;
        endcase
      end
      rbm_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.blk_last) begin
          state_nxt = rbm_pkg::ST_RESULT;
        end
      end
      // last block write-back lands in the first result cycle
      rbm_pkg::ST_MERGE: begin
        cmd.merge_rd = 1'b1;
        if (stat.blk_last) begin
          state_nxt = rbm_pkg::ST_RESULT;
        end
      end
      rbm_pkg::ST_QUERY: begin
        cmd.query_rd = 1'b1;
        state_nxt    = rbm_pkg::ST_QTAKE;
      end
      rbm_pkg::ST_QTAKE: begin
        cmd.query_take = 1'b1;
        state_nxt      = rbm_pkg::ST_RESULT;
      end
      rbm_pkg::ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = rbm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rbm_pkg::ST_INIT;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/rbm_datapath.sv */
`default_nettype none
module rbm_datapath (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire rbm_pkg::cmd_t            cmd,
  output rbm_pkg::stat_t                stat,
  input  wire logic [rbm_pkg::OP_W-1:0] in_operation,
  input  wire logic [rbm_pkg::ID_W-1:0] in_source_node,
  input  wire logic [rbm_pkg::ID_W-1:0] in_target_node,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [rbm_pkg::ID_W-1:0]      out_new_node_id,
  output logic                          out_reaches,
  output logic                          out_error
);

  // captured item
  logic [rbm_pkg::OP_W-1:0]  op_r;
  logic [rbm_pkg::ID_W-1:0]  src_r;
  logic [rbm_pkg::ID_W-1:0]  dst_r;

  logic [rbm_pkg::CNT_W-1:0] count_r;
  logic [rbm_pkg::BLK_W-1:0] blk_r;
  logic                      wb_pend_r;
  logic [rbm_pkg::BLK_W-1:0] wb_blk_r;

  logic [rbm_pkg::ID_W-1:0]  res_id_r;
  logic                      res_reach_r;
  logic                      res_err_r;

  logic                      out_valid_r;
  logic [rbm_pkg::ID_W-1:0]  out_id_r;
  logic                      out_reach_r;
  logic                      out_err_r;

  logic [rbm_pkg::BLOCK_BITS-1:0] mem_r [rbm_pkg::MEM_DEPTH];
  logic [rbm_pkg::BLOCK_BITS-1:0] rd_a_r;
  logic [rbm_pkg::BLOCK_BITS-1:0] rd_b_r;

  logic [rbm_pkg::ROW_W-1:0]  src_row;
  logic [rbm_pkg::ROW_W-1:0]  dst_row;
  logic [rbm_pkg::ROW_W-1:0]  new_row;
  logic [rbm_pkg::BLK_W-1:0]  src_blk;
  logic [rbm_pkg::OFF_W-1:0]  src_off;
  logic                       src_ok;
  logic                       dst_ok;
  logic                       table_full;

  rbm_pkg::act_t              dec_act;
  logic [rbm_pkg::ID_W-1:0]   dec_id;
  logic                       dec_reach;
  logic                       dec_err;
  logic                       dec_inc;

  logic [rbm_pkg::ADDR_W-1:0] rd_addr_a;
  logic [rbm_pkg::ADDR_W-1:0] rd_addr_b;
  logic                       wr_en;
  logic [rbm_pkg::ADDR_W-1:0] wr_addr;
  logic [rbm_pkg::BLOCK_BITS-1:0] wr_data;
  logic [rbm_pkg::BLOCK_BITS-1:0] src_mark;

  assign src_row    = rbm_pkg::ROW_W'(src_r);
  assign dst_row    = rbm_pkg::ROW_W'(dst_r);
  assign new_row    = rbm_pkg::ROW_W'(res_id_r);
  assign src_blk    = rbm_pkg::BLK_W'(src_r >> rbm_pkg::OFF_W);
  assign src_off    = src_r[rbm_pkg::OFF_W-1:0];
  assign src_ok     = rbm_pkg::CMP_W'(src_r) < rbm_pkg::CMP_W'(count_r);
  assign dst_ok     = rbm_pkg::CMP_W'(dst_r) < rbm_pkg::CMP_W'(count_r);
  assign table_full = count_r == rbm_pkg::CNT_W'(rbm_pkg::MAX_NODES);

  always_comb begin
    dec_act   = rbm_pkg::ACT_NONE;
    dec_id    = '0;
    dec_reach = 1'b0;
    dec_err   = 1'b0;
    dec_inc   = 1'b0;
    case (op_r)
      rbm_pkg::OP_ADD_NODE: begin
        if (table_full) begin
          dec_err = 1'b1;
        end else begin
          dec_id  = rbm_pkg::ID_W'(count_r);
          dec_inc = 1'b1;
          dec_act = rbm_pkg::ACT_CLEAR;
        end
      end
      rbm_pkg::OP_ADD_EDGE: begin
        if (!(src_ok && dst_ok)) begin
          dec_err = 1'b1;
        end else if (src_r != dst_r) begin
          dec_act = rbm_pkg::ACT_MERGE;
        end
      end
      rbm_pkg::OP_QUERY: begin
        if (src_r == dst_r) begin
          dec_reach = 1'b1;
        end else if (!(src_ok && dst_ok)) begin
          dec_err = 1'b1;
        end else begin
          dec_act = rbm_pkg::ACT_QUERY;
        end
      end
      default: begin
        dec_err = 1'b1;
      end
    endcase
  end

  assign stat.act      = dec_act;
  assign stat.blk_last = blk_r == rbm_pkg::BLK_W'(rbm_pkg::ROW_BLOCKS - 1);
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_operation;
      src_r <= in_source_node;
      dst_r <= in_target_node;
    end
    if (cmd.decide) begin
      res_err_r   <= dec_err;
      res_reach_r <= dec_reach;
    end else if (cmd.query_take) begin
      res_reach_r <= rd_a_r[src_off];
    end
    if (cmd.out_load) begin
      out_id_r    <= res_id_r;
      out_reach_r <= res_reach_r;
      out_err_r   <= res_err_r;
    end
    wb_blk_r <= blk_r;
  end

  // res_id_r also picks the row to wipe, so it starts at the reserved node
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= rbm_pkg::CNT_W'(1);
      blk_r       <= '0;
      wb_pend_r   <= 1'b0;
      res_id_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.decide && dec_inc) begin
        count_r <= count_r + rbm_pkg::CNT_W'(1);
      end
      if (cmd.blk_clr) begin
        blk_r <= '0;
      end else if (cmd.clear_wr || cmd.merge_rd) begin
        blk_r <= blk_r + rbm_pkg::BLK_W'(1);
      end
      wb_pend_r <= cmd.merge_rd;
      if (cmd.decide) begin
        res_id_r <= dec_id;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // row t holds a bit for each node found to reach t when an edge into t was added
  assign rd_addr_a = cmd.query_rd ? {dst_row, src_blk} : {src_row, blk_r};
  assign rd_addr_b = {dst_row, blk_r};
  assign src_mark  = (wb_blk_r == src_blk) ?
                     (rbm_pkg::BLOCK_BITS'(1) << src_off) : '0;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {new_row, blk_r};
    wr_data = '0;
    if (wb_pend_r) begin
      wr_en   = 1'b1;
      wr_addr = {dst_row, wb_blk_r};
      wr_data = rd_a_r | rd_b_r | src_mark;
    end else if (cmd.clear_wr) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_r[rd_addr_a];
    rd_b_r <= mem_r[rd_addr_b];
  end

  assign out_valid       = out_valid_r;
  assign out_new_node_id = out_id_r;
  assign out_reaches     = out_reach_r;
  assign out_error       = out_err_r;

endmodule
`default_nettype wire
